/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is applied
`define APS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define APS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/aps_pkg.sv */
// ----------------------------------------------------------------------------
// aps_pkg
// types and constants of the analog pad serial responder
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int unsigned PAD_W = 15;

  // event codes
  localparam logic [1:0] CMD_SELECT = 2'd0;
  localparam logic [1:0] CMD_CLOCK  = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  // acknowledge delay codes
  localparam logic [1:0] DLY_NONE = 2'd0;
  localparam logic [1:0] DLY_128  = 2'd1;
  localparam logic [1:0] DLY_256  = 2'd2;

  // protocol bytes
  localparam logic [7:0] HDR_BYTE   = 8'h01;
  localparam logic [7:0] HDR_REPLY  = 8'h23;
  localparam logic [7:0] POLL_BYTE  = 8'h42;
  localparam logic [7:0] ID_BYTE    = 8'h5A;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_COMMAND = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_IDLE    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             line_level;
    logic [7:0]       buttons_low;
    logic [7:0]       buttons_high;
    logic [PAD_W-1:0] twist_right;
    logic [PAD_W-1:0] twist_left;
    logic [PAD_W-1:0] analog_one;
    logic [PAD_W-1:0] analog_two;
    logic [PAD_W-1:0] analog_shoulder;
  } in_item_t;

  typedef struct packed {
    logic       data_out;
    logic       ack_level;
    logic [1:0] ack_delay;
  } out_item_t;

endpackage

/* rtl/aps_stream_if.sv */
// ----------------------------------------------------------------------------
// aps_stream_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
interface aps_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/analog_pad_serial_responder_top.sv */
// pipeline: a request is held in the request register and then its result in
//   the result register, which loads only while it is free
// throughput: one request per cycle unless a result is stalled, set by the
//   single register-to-register pass of the decode, reply-shift and pad scaling logic
// reset: asynchronous, active low; clears both pipeline valids and all
//   responder state (select low, header phase, empty reply, zero pad data)
// ----------------------------------------------------------------------------
// analog_pad_serial_responder_top
// bit-serial pad responder: takes select, clock-bit and pad-load events and
// returns data-out bit, acknowledge level and acknowledge delay per event
// ----------------------------------------------------------------------------
module analog_pad_serial_responder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  aps_stream_if.sink   in_i,
  aps_stream_if.source out_o
);

  // --------------------------------------------------------------------------
  // pipeline control
  // stage 1 holds the accepted request, stage 2 the finished result
  // --------------------------------------------------------------------------
  logic                s1_valid_q, s1_valid_d;
  aps_pkg::in_item_t   s1_q;
  logic                out_valid_q, out_valid_d;
  aps_pkg::out_item_t  out_q, res_d;

  logic in_fire;
  logic out_free;
  logic advance;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;
  // request in stage 1 executes and moves to the result register
  assign advance  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.payload;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // --------------------------------------------------------------------------
  // pad scaling of the staged request (used only by a load event)
  // --------------------------------------------------------------------------
  logic [7:0] twist_s;
  logic [7:0] analog_one_s;
  logic [7:0] analog_two_s;
  logic [7:0] analog_shoulder_s;

  aps_scale u_scale (
    .twist_right_i     (s1_q.twist_right),
    .twist_left_i      (s1_q.twist_left),
    .analog_one_i      (s1_q.analog_one),
    .analog_two_i      (s1_q.analog_two),
    .analog_shoulder_i (s1_q.analog_shoulder),
    .twist_o           (twist_s),
    .analog_one_o      (analog_one_s),
    .analog_two_o      (analog_two_s),
    .analog_shoulder_o (analog_shoulder_s)
  );

  // --------------------------------------------------------------------------
  // responder state
  // --------------------------------------------------------------------------
  logic            sel_q, sel_d;
  logic [2:0]      bit_q, bit_d;
  logic [7:0]      rx_q, rx_d;
  aps_pkg::phase_e phase_q, phase_d;
  logic [7:0]      reply_q [8];
  logic [7:0]      reply_d [8];
  logic [2:0]      ridx_q, ridx_d;
  logic [2:0]      rleft_q, rleft_d;
  logic [7:0]      btn_lo_q, btn_lo_d;
  logic [7:0]      btn_hi_q, btn_hi_d;
  logic [7:0]      twist_q, twist_d;
  logic [7:0]      an_one_q, an_one_d;
  logic [7:0]      an_two_q, an_two_d;
  logic [7:0]      an_sh_q, an_sh_d;

  logic [7:0]      cur_byte;
  logic            dout;
  logic [1:0]      delay;

  // byte currently being shifted out
  assign cur_byte = reply_q[ridx_q];

  always_comb begin
    sel_d    = sel_q;
    bit_d    = bit_q;
    rx_d     = rx_q;
    phase_d  = phase_q;
    reply_d  = reply_q;
    ridx_d   = ridx_q;
    rleft_d  = rleft_q;
    btn_lo_d = btn_lo_q;
    btn_hi_d = btn_hi_q;
    twist_d  = twist_q;
    an_one_d = an_one_q;
    an_two_d = an_two_q;
    an_sh_d  = an_sh_q;
    dout     = 1'b1;
    delay    = aps_pkg::DLY_NONE;

    unique case (s1_q.cmd)
      aps_pkg::CMD_SELECT: begin
        // rising select restarts the transaction, receive byte is kept
        if (!sel_q && s1_q.line_level) begin
          phase_d = aps_pkg::PH_HEADER;
          bit_d   = 3'd0;
          ridx_d  = 3'd0;
          rleft_d = 3'd0;
        end
        sel_d = s1_q.line_level;
      end

      aps_pkg::CMD_CLOCK: begin
        // clocks with select low are ignored
        if (sel_q) begin
          if (rleft_q != 3'd0) begin
            dout = cur_byte[bit_q];
          end
          // lsb first into the receive byte
          rx_d[bit_q] = s1_q.line_level;
          bit_d       = bit_q + 3'd1;

          // byte boundary
          if (bit_q == 3'd7) begin
            if (rleft_q != 3'd0) begin
              ridx_d  = ridx_q + 3'd1;
              rleft_d = rleft_q - 3'd1;
            end
            unique case (phase_q)
              aps_pkg::PH_HEADER: begin
                if (rx_d != aps_pkg::HDR_BYTE) begin
                  phase_d = aps_pkg::PH_IDLE;
                end else begin
                  reply_d[0] = aps_pkg::HDR_REPLY;
                  ridx_d     = 3'd0;
                  rleft_d    = 3'd1;
                  phase_d    = aps_pkg::PH_COMMAND;
                  delay      = aps_pkg::DLY_256;
                end
              end
              aps_pkg::PH_COMMAND: begin
                reply_d[0] = aps_pkg::ID_BYTE;
                if (rx_d == aps_pkg::POLL_BYTE) begin
                  // snapshot the pad report
                  reply_d[1] = aps_pkg::BYTE_ONES ^ btn_lo_q;
                  reply_d[2] = aps_pkg::BYTE_ONES ^ btn_hi_q;
                  reply_d[3] = twist_q;
                  reply_d[4] = an_one_q;
                  reply_d[5] = an_two_q;
                  reply_d[6] = an_sh_q;
                  ridx_d     = 3'd0;
                  rleft_d    = 3'd7;
                  phase_d    = aps_pkg::PH_DATA;
                  delay      = aps_pkg::DLY_256;
                end else begin
                  // unknown command: go quiet until select rises
                  phase_d    = aps_pkg::PH_IDLE;
                  reply_d[1] = 8'd0;
                  reply_d[2] = 8'd0;
                  ridx_d     = 3'd0;
                  rleft_d    = 3'd0;
                end
              end
              aps_pkg::PH_DATA: begin
                if (rleft_d != 3'd0) begin
                  delay = aps_pkg::DLY_128;
                end
              end
              aps_pkg::PH_IDLE: begin
              end
              default: begin
              end
            endcase
          end
        end
      end

      aps_pkg::CMD_LOAD: begin
        btn_lo_d = s1_q.buttons_low;
        btn_hi_d = s1_q.buttons_high;
        twist_d  = twist_s;
        an_one_d = analog_one_s;
        an_two_d = analog_two_s;
        an_sh_d  = analog_shoulder_s;
      end

      default: begin
        // unused event code behaves as an idle event
      end
    endcase

    res_d.data_out  = dout;
    // acknowledge follows the state after the event
    res_d.ack_level = sel_d && (bit_d == 3'd0) && (rleft_d != 3'd0);
    res_d.ack_delay = delay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= 1'b0;
      bit_q    <= 3'd0;
      rx_q     <= 8'd0;
      phase_q  <= aps_pkg::PH_HEADER;
      for (int i = 0; i < 8; i++) begin
        reply_q[i] <= 8'd0;
      end
      ridx_q   <= 3'd0;
      rleft_q  <= 3'd0;
      btn_lo_q <= 8'd0;
      btn_hi_q <= 8'd0;
      twist_q  <= 8'd0;
      an_one_q <= 8'd0;
      an_two_q <= 8'd0;
      an_sh_q  <= 8'd0;
    end else if (advance) begin
      sel_q    <= sel_d;
      bit_q    <= bit_d;
      rx_q     <= rx_d;
      phase_q  <= phase_d;
      reply_q  <= reply_d;
      ridx_q   <= ridx_d;
      rleft_q  <= rleft_d;
      btn_lo_q <= btn_lo_d;
      btn_hi_q <= btn_hi_d;
      twist_q  <= twist_d;
      an_one_q <= an_one_d;
      an_two_q <= an_two_d;
      an_sh_q  <= an_sh_d;
    end
  end

endmodule

/* rtl/aps_scale.sv */
// ----------------------------------------------------------------------------
// aps_scale
// scales 15-bit twist and pressure inputs to 8-bit report bytes
// ----------------------------------------------------------------------------
module aps_scale (
  input  logic [aps_pkg::PAD_W-1:0] twist_right_i,
  input  logic [aps_pkg::PAD_W-1:0] twist_left_i,
  input  logic [aps_pkg::PAD_W-1:0] analog_one_i,
  input  logic [aps_pkg::PAD_W-1:0] analog_two_i,
  input  logic [aps_pkg::PAD_W-1:0] analog_shoulder_i,
  output logic [7:0]                twist_o,
  output logic [7:0]                analog_one_o,
  output logic [7:0]                analog_two_o,
  output logic [7:0]                analog_shoulder_o
);

  // (v*255 + 16383) / 32767, divide by 2^15-1 as (x + (x>>15) + 1) >> 15
  function automatic logic [7:0] scale_pad(input logic [14:0] v);
    logic [22:0] x;
    logic [23:0] s;
    x = {v, 8'd0} - {8'd0, v} + 23'd16383;
    s = {1'b0, x} + {16'd0, x[22:15]} + 24'd1;
    return s[22:15];
  endfunction

  logic [29:0] lx;
  logic [30:0] ls;
  logic [15:0] lq;
  logic [15:0] mid;
  logic [23:0] ty;
  logic [24:0] ts;

  always_comb begin
    // left twist scaled to 0..32768
    lx  = {twist_left_i, 15'd0} + 30'd16383;
    ls  = {1'b0, lx} + {16'd0, lx[29:15]} + 31'd1;
    lq  = ls[30:15];
    // centered value, always in 0..65535
    mid = 16'h8000 + {1'b0, twist_right_i} - lq;
    // (mid*255 + 32767) / 65535
    ty  = {mid, 8'd0} - {8'd0, mid} + 24'd32767;
    ts  = {1'b0, ty} + {17'd0, ty[23:16]} + 25'd1;
  end

  assign twist_o           = ts[23:16];
  assign analog_one_o      = scale_pad(analog_one_i);
  assign analog_two_o      = scale_pad(analog_two_i);
  assign analog_shoulder_o = scale_pad(analog_shoulder_i);

endmodule

/* rtl/aps_checker.sv */
// ----------------------------------------------------------------------------
// aps_checker
// port-level checks on the responder result channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       data_out_i,
  input logic       ack_level_i,
  input logic [1:0] ack_delay_i
);

  logic       stall;
  logic       delay_set;
  logic [3:0] res;

  assign stall     = out_valid_i && !out_ready_i;
  assign delay_set = out_valid_i && (ack_delay_i != aps_pkg::DLY_NONE);
  assign res       = {data_out_i, ack_level_i, ack_delay_i};

  // a delayed pulse is only scheduled while reply bytes are pending
  `APS_ASSERT(a_delay_has_ack, clk_i, rst_ni, delay_set |-> ack_level_i, "delay without ack")

  // a stalled result holds its payload
  `APS_ASSERT(a_out_hold, clk_i, rst_ni, stall |=> out_valid_i && $stable(res), "result not held")

  // once reset is applied no result is offered
  `APS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_i, "result valid during reset")

endmodule

bind analog_pad_serial_responder_top aps_checker u_aps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .data_out_i  (out_o.payload.data_out),
  .ack_level_i (out_o.payload.ack_level),
  .ack_delay_i (out_o.payload.ack_delay)
);
